>>> rtl/core/chte_pkg.sv
`default_nettype none
package chte_pkg;

	// Width of the entry count field in a result.
	localparam int ENTRY_W = 11;

	// Request codes.
	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_NOP    = 2'd3
	} req_t;

endpackage
`default_nettype wire

>>> rtl/core/chte_req_if.sv
`default_nettype none
interface chte_req_if import chte_pkg::*; #(
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
);
	logic                   valid;
	logic                   ready;
	req_t                   req_type;
	logic [KEY_WIDTH-1:0]   key;
	logic [VALUE_WIDTH-1:0] value;

	modport source (output valid, req_type, key, value, input ready);
	modport sink   (input valid, req_type, key, value, output ready);
endinterface
`default_nettype wire

>>> rtl/core/chte_rsp_if.sv
`default_nettype none
interface chte_rsp_if import chte_pkg::*; #(
	parameter int VALUE_WIDTH = 32
);
	logic                   valid;
	logic                   ready;
	logic                   found;
	logic [VALUE_WIDTH-1:0] result_value;
	logic                   status;
	logic [ENTRY_W-1:0]     entry_count;

	modport source (output valid, found, result_value, status, entry_count, input ready);
	modport sink   (input valid, found, result_value, status, entry_count, output ready);
endinterface
`default_nettype wire

>>> rtl/core/chte_ram.sv
`default_nettype none
module chte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/chained_hash_table_engine.sv
`default_nettype none
// Key-to-value hash table with separate chaining over a fixed node pool. Each request
// yields exactly one response. The slot of a key is ((key << 18) + key) mod SLOTS. The
// hash word is reduced 16 bits at a time by one shared 32 x 32 multiplier. Each step joins
// the running remainder with the next 16 bits of the hash word and estimates the quotient
// with a multiply by the reciprocal of SLOTS. A second pass through the same multiplier
// with one compare and subtract then fixes the remainder, for each 16-bit chunk of the
// hash word in turn. The steps of each request:
// - An insert hashes the key, reads the slot head, then writes the new node and head.
// - A lookup hashes the key, reads the slot head, then walks the chain, if any, node by node.
// - A refused insert or a request of the unused code goes straight to the response.
// - A clear walks the used-slot list and empties each slot head through the single
//   write port. A clear of an empty table goes straight to the response.
// After reset the block sweeps the whole slot-head memory before it takes its first
// request. The block takes one request at a time; a response waits in its register
// until it is taken.
module chained_hash_table_engine import chte_pkg::*; #(
	parameter int SLOTS       = 4093,
	parameter int NODES       = 1024,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	chte_req_if.sink  req,
	chte_rsp_if.source rsp
);
	localparam int HW  = (KEY_WIDTH + 19 > 64) ? 64 : KEY_WIDTH + 19;
	localparam int NCH = (HW + 15) / 16;
	localparam int HPW = NCH * 16;
	localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int SW  = $clog2(SLOTS);
	localparam int UW  = $clog2(SLOTS + 1);
	localparam int NW  = $clog2(NODES + 1);
	localparam int IW  = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int NDW = KEY_WIDTH + VALUE_WIDTH + NW;
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(SLOTS));

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_HASH_MUL, ST_HASH_SUB, ST_HEAD_RD, ST_HEAD_WT,
		ST_WALK, ST_CLR_RD, ST_CLR_WR, ST_DONE
	} state_t;

	state_t                 state_q;
	req_t                   req_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [HPW-1:0]         h_q;
	logic [CHW-1:0]         ch_q;
	logic [31:0]            x_q;
	logic [31:0]            q_q;
	logic [SW-1:0]          rem_q;
	logic [SW-1:0]          init_q;
	logic [UW-1:0]          used_cnt_q;
	logic [UW-1:0]          clr_q;
	logic [NW-1:0]          nc_q;
	logic                   found_q;
	logic [VALUE_WIDTH-1:0] rv_q;
	logic                   status_q;

	// Memory ports.
	logic          head_we, head_re;
	logic [SW-1:0] head_waddr;
	logic [NW-1:0] head_wdata, head_rdata;
	logic          node_we, node_re;
	logic [IW-1:0] node_waddr, node_raddr;
	logic [NDW-1:0] node_wdata, node_rdata;
	logic          used_we, used_re;
	logic [SW-1:0] used_waddr, used_rdata;

	logic [KEY_WIDTH-1:0]   nd_key;
	logic [VALUE_WIDTH-1:0] nd_val;
	logic [NW-1:0]          nd_link;
	logic [HPW-1:0]         hsum;
	logic [31:0]            hx;
	logic [31:0]            mul_a, mul_b;
	logic [63:0]            prod;
	logic [31:0]            diff;
	logic                   ins_new_slot;

	assign {nd_key, nd_val, nd_link} = node_rdata;

	// Hash word, padded to whole 16-bit chunks.
	assign hsum = (HPW'(req.key) << 18) + HPW'(req.key);

	// Shared multiplier: quotient estimate first, then quotient times SLOTS.
	assign hx    = {16'(rem_q), h_q[HPW-1 -: 16]};
	assign mul_a = (state_q == ST_HASH_SUB) ? q_q : hx;
	assign mul_b = (state_q == ST_HASH_SUB) ? 32'(SLOTS) : RECIP;
	assign prod  = 64'(mul_a) * 64'(mul_b);
	assign diff  = x_q - prod[31:0];

	assign ins_new_slot = (head_rdata == '0) && (used_cnt_q < UW'(SLOTS));

	// Memory control by state.
	always_comb begin
		head_we    = 1'b0;
		head_waddr = rem_q;
		head_wdata = '0;
		head_re    = 1'b0;
		node_we    = 1'b0;
		node_waddr = IW'(nc_q);
		node_wdata = {key_q, val_q, head_rdata};
		node_re    = 1'b0;
		node_raddr = IW'(head_rdata - NW'(1));
		used_we    = 1'b0;
		used_waddr = SW'(used_cnt_q);
		used_re    = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				head_we    = 1'b1;
				head_waddr = init_q;
			end
			ST_HEAD_RD: begin
				head_re = 1'b1;
			end
			ST_HEAD_WT: begin
				if (req_q == REQ_INSERT) begin
					head_we    = 1'b1;
					head_wdata = nc_q + NW'(1);
					node_we    = 1'b1;
					used_we    = ins_new_slot;
				end else begin
					node_re = (head_rdata != '0);
				end
			end
			ST_WALK: begin
				node_re    = 1'b1;
				node_raddr = IW'(nd_link - NW'(1));
			end
			ST_CLR_RD: begin
				used_re = 1'b1;
			end
			ST_CLR_WR: begin
				head_we    = 1'b1;
				head_waddr = used_rdata;
				used_re    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	chte_ram #(.WIDTH(NW), .DEPTH(SLOTS)) u_head (
		.clk, .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.re(head_re), .raddr(rem_q), .rdata(head_rdata)
	);

	chte_ram #(.WIDTH(NDW), .DEPTH(NODES)) u_node (
		.clk, .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
		.re(node_re), .raddr(node_raddr), .rdata(node_rdata)
	);

	chte_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_used (
		.clk, .we(used_we), .waddr(used_waddr), .wdata(rem_q),
		.re(used_re), .raddr(SW'(clr_q)), .rdata(used_rdata)
	);

	assign req.ready        = (state_q == ST_IDLE);
	assign rsp.valid        = (state_q == ST_DONE);
	assign rsp.found        = found_q;
	assign rsp.result_value = rv_q;
	assign rsp.status       = status_q;
	assign rsp.entry_count  = ENTRY_W'(nc_q);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			init_q     <= '0;
			used_cnt_q <= '0;
			nc_q       <= '0;
			clr_q      <= '0;
			ch_q       <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					init_q <= init_q + SW'(1);
					if (init_q == SW'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						req_q    <= req.req_type;
						key_q    <= req.key;
						val_q    <= req.value;
						h_q      <= hsum;
						rem_q    <= '0;
						ch_q     <= CHW'(NCH - 1);
						clr_q    <= '0;
						found_q  <= 1'b0;
						rv_q     <= '0;
						status_q <= 1'b0;
						unique case (req.req_type)
							REQ_INSERT: begin
								if (nc_q == NW'(NODES)) begin
									status_q <= 1'b1;
									state_q  <= ST_DONE;
								end else begin
									state_q <= ST_HASH_MUL;
								end
							end
							REQ_LOOKUP: state_q <= ST_HASH_MUL;
							REQ_CLEAR: begin
								if (used_cnt_q == '0) begin
									nc_q    <= '0;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_CLR_RD;
								end
							end
							REQ_NOP: state_q <= ST_DONE;
						endcase
					end
				end
				// Quotient estimate, at most one below the true quotient.
				ST_HASH_MUL: begin
					x_q     <= hx;
					q_q     <= prod[63:32];
					h_q     <= h_q << 16;
					state_q <= ST_HASH_SUB;
				end
				// Remainder from the estimate, with one final correction.
				ST_HASH_SUB: begin
					rem_q <= (diff >= 32'(SLOTS)) ? SW'(diff - 32'(SLOTS)) : SW'(diff);
					ch_q  <= ch_q - CHW'(1);
					if (ch_q == '0) begin
						state_q <= ST_HEAD_RD;
					end else begin
						state_q <= ST_HASH_MUL;
					end
				end
				ST_HEAD_RD: begin
					state_q <= ST_HEAD_WT;
				end
				ST_HEAD_WT: begin
					if (req_q == REQ_INSERT) begin
						nc_q    <= nc_q + NW'(1);
						if (ins_new_slot) begin
							used_cnt_q <= used_cnt_q + UW'(1);
						end
						state_q <= ST_DONE;
					end else if (head_rdata == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					// Node data is valid here; chains only link to earlier nodes.
					if (nd_key == key_q) begin
						found_q <= 1'b1;
						rv_q    <= nd_val;
						state_q <= ST_DONE;
					end else if (nd_link == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_CLR_RD: begin
					clr_q   <= clr_q + UW'(1);
					state_q <= ST_CLR_WR;
				end
				ST_CLR_WR: begin
					if (clr_q == used_cnt_q) begin
						used_cnt_q <= '0;
						nc_q       <= '0;
						state_q    <= ST_DONE;
					end else begin
						clr_q <= clr_q + UW'(1);
					end
				end
				ST_DONE: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
